### rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Status codes, operation codes and the shared divider request and response structs.
// ---------------------------------------------------------------------------
package rau_pkg;

  localparam int DW = 32;
  localparam int WW = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Shared divide unit handshake
  typedef struct packed {
    logic          start;
    logic [WW-1:0] dividend;
    logic [WW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [WW-1:0] quot;
    logic [WW-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/rational_arith_unit_core.sv
// Timing: an invalid operand is answered without the divider; otherwise the
// time is set by the shared 64-step divider, one divider run per Euclid step
// and per exact division, so it grows with the length of the Euclid chains.
// Throughput: one item at a time; in_tready is low from accept until the
// result is taken. Result is held in an output register until out_tready.
// Reset: synchronous active-low rst_n clears the sequencer and handshakes.
// ---------------------------------------------------------------------------
// rational_arith_unit_core: top level of the rational arithmetic unit
// Stream ports around the sequencer and the shared divider.
// ---------------------------------------------------------------------------
module rational_arith_unit_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] operation, [33:2] lhs_numerator, [65:34] lhs_denominator,
  // [97:66] rhs_numerator, [129:98] rhs_denominator, rest zero
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] result_numerator, [62:32] result_denominator, [64:63] status
  output logic [71:0]  out_tdata
);

  logic              busy_r, ovld_r, done;
  logic [31:0]       rn;
  logic [30:0]       rd;
  logic [1:0]        rs;
  logic [71:0]       odat_r;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;
  logic              acc;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = !busy_r;

  rau_seq u_seq (
    .clk, .rst_n, .start(acc), .op(in_tdata[1:0]),
    .an(in_tdata[33:2]), .ad(in_tdata[65:34]),
    .bn(in_tdata[97:66]), .bd(in_tdata[129:98]),
    .done, .res_num(rn), .res_den(rd), .res_st(rs), .dreq, .drsp
  );

  rau_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (acc) busy_r <= 1'b1;
      if (done) ovld_r <= 1'b1;
      if (ovld_r && out_tready) begin
        ovld_r <= 1'b0;
        busy_r <= 1'b0;
      end
    end
    if (done) odat_r <= {7'd0, rs, rd, rn};
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odat_r;

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy_r) else $error("result without item");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (busy_r && !ovld_r)) else $error("done while output full");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[64:63] != 2'd0) |-> (out_tdata[31:0] == 32'd0))
    else $error("error result nonzero");
`endif

endmodule

### rtl/rau_div.sv
// ---------------------------------------------------------------------------
// rau_div: shared 64-bit restoring divider
// One quotient bit per cycle; done pulses once the last quotient bit is in.
// ---------------------------------------------------------------------------
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);

  logic [rau_pkg::WW-1:0] q_r, q_nxt;
  logic [rau_pkg::WW:0]   rem_r, rem_nxt;
  logic [rau_pkg::WW-1:0] dvs_r, dvs_nxt;
  logic [6:0]             cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [rau_pkg::WW:0]   trial;

  // One shift-subtract step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[rau_pkg::WW-1:0], q_r[rau_pkg::WW-1]} - {1'b0, dvs_r};
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[rau_pkg::WW]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[rau_pkg::WW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[rau_pkg::WW-1:0], q_r[rau_pkg::WW-1]};
        q_nxt   = {q_r[rau_pkg::WW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'(rau_pkg::WW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[rau_pkg::WW-1:0];

endmodule

### rtl/rau_seq.sv
// ---------------------------------------------------------------------------
// rau_seq: sequencer for rational arithmetic
// Steps operand reduction, cross products and result reduction, using the
// shared divider for every GCD step and exact division.
// ---------------------------------------------------------------------------
module rau_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [1:0]               op,
  input  logic [rau_pkg::DW-1:0]   an,
  input  logic [rau_pkg::DW-1:0]   ad,
  input  logic [rau_pkg::DW-1:0]   bn,
  input  logic [rau_pkg::DW-1:0]   bd,
  output logic                     done,
  output logic [rau_pkg::DW-1:0]   res_num,
  output logic [rau_pkg::DW-2:0]   res_den,
  output logic [1:0]               res_st,
  output rau_pkg::div_req_t        dreq,
  input  rau_pkg::div_rsp_t        drsp
);

  localparam int W = rau_pkg::WW;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RED, S_GCDW, S_DNW, S_DDW, S_NEXT,
    S_LCMW, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  // working fraction, gcd pair, operand store
  logic          neg_r;
  logic [W-1:0]  num_r, den_r, ga_r, gb_r, g_r;
  logic          aneg_r, bneg_r;
  logic [W-1:0]  anum_r, aden_r, bnum_r, bden_r;
  logic [1:0]    which_r;      // 0 lhs, 1 rhs, 2 result; S_LCMW uses 3, 2, 1 as its phases
  logic [1:0]    op_r;
  logic [1:0]    st_r;
  logic [W-1:0]  ma_r, mb_r, q_r;
  logic [rau_pkg::DW-1:0] on_r;
  logic [rau_pkg::DW-2:0] od_r;
  logic [W-1:0]  mul_a, mul_b;
  logic [W-1:0]  prod;
  logic [W:0]    sum;
  logic [W-1:0]  half;
  logic          issue;

  // magnitude of a signed input word
  function automatic logic [W-1:0] mag(input logic [rau_pkg::DW-1:0] v);
    logic [rau_pkg::DW-1:0] m;
    m = v[rau_pkg::DW-1] ? (~v + 1'b1) : v;
    return W'(m) | (W'(v[rau_pkg::DW-1] && (m == '0)) << (rau_pkg::DW - 1));
  endfunction

  // one 32x32 product with a 64-bit result (all factors fit 32 bits here)
  assign prod = W'(mul_a[rau_pkg::DW-1:0]) * W'(mul_b[rau_pkg::DW-1:0]);
  assign half = W'(1) << (rau_pkg::DW - 1);
  assign sum  = {1'b0, ma_r} + {1'b0, mb_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        if (op_r == rau_pkg::OP_MUL) begin
          mul_a = anum_r; mul_b = bnum_r;
        end else if (op_r == rau_pkg::OP_DIV) begin
          mul_a = anum_r; mul_b = bden_r;
        end else begin
          mul_a = anum_r; mul_b = q_r;
        end
      end
      S_MUL2: begin
        if (op_r == rau_pkg::OP_MUL) begin
          mul_a = aden_r; mul_b = bden_r;
        end else if (op_r == rau_pkg::OP_DIV) begin
          mul_a = aden_r; mul_b = bnum_r;
        end else begin
          mul_a = bnum_r; mul_b = g_r;
        end
      end
      S_MUL3: begin
        mul_a = aden_r; mul_b = q_r;
      end
      default: ;
    endcase
  end

  // divider start: every state that hands the divider a new operand pair
  always_comb begin
    issue = 1'b0;
    case (state_r)
      S_RED:   issue = (num_r != '0);
      S_GCDW:  issue = drsp.done;
      S_DNW:   issue = drsp.done;
      S_NEXT:  issue = (which_r == 2'd1) &&
                       (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB);
      S_LCMW:  issue = drsp.done && (which_r != 2'd1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= issue;
      case (state_r)
        S_IDLE: if (start) begin
          op_r    <= op;
          st_r    <= rau_pkg::ST_OK;
          anum_r  <= mag(an);  aden_r <= mag(ad);
          bnum_r  <= mag(bn);  bden_r <= mag(bd);
          aneg_r  <= an[rau_pkg::DW-1] ^ ad[rau_pkg::DW-1];
          bneg_r  <= bn[rau_pkg::DW-1] ^ bd[rau_pkg::DW-1];
          which_r <= 2'd0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (aden_r == '0 || bden_r == '0) begin
            st_r <= rau_pkg::ST_INVALID;
            state_r <= S_OUT;
          end else begin
            neg_r <= aneg_r; num_r <= anum_r; den_r <= aden_r;
            state_r <= S_RED;
          end
        end
        // start reduction of num_r/den_r; a zero numerator reduces to 0/1
        S_RED: begin
          if (num_r == '0) begin
            neg_r <= 1'b0; den_r <= W'(1);
            g_r <= W'(1);
            state_r <= S_NEXT;
          end else begin
            dreq.dividend <= num_r;
            dreq.divisor <= den_r;
            gb_r <= den_r;
            state_r <= S_GCDW;
          end
        end
        // Euclid: a,b -> b, a mod b
        S_GCDW: if (drsp.done) begin
          if (drsp.rem == '0) begin
            g_r <= gb_r;
            dreq.dividend <= num_r;
            dreq.divisor <= gb_r;
            state_r <= S_DNW;
          end else begin
            ga_r <= gb_r;
            gb_r <= drsp.rem;
            dreq.dividend <= gb_r;
            dreq.divisor <= drsp.rem;
          end
        end
        S_DNW: if (drsp.done) begin
          num_r <= drsp.quot;
          dreq.dividend <= den_r;
          dreq.divisor <= g_r;
          state_r <= S_DDW;
        end
        S_DDW: if (drsp.done) begin
          den_r <= drsp.quot;
          state_r <= S_NEXT;
        end
        // store reduced fraction, move on
        S_NEXT: begin
          case (which_r)
            2'd0: begin
              anum_r <= num_r; aden_r <= den_r; aneg_r <= neg_r;
              neg_r <= bneg_r; num_r <= bnum_r; den_r <= bden_r;
              which_r <= 2'd1;
              state_r <= S_RED;
            end
            2'd1: begin
              bnum_r <= num_r; bden_r <= den_r;
              bneg_r <= (op_r == rau_pkg::OP_SUB) ? ~neg_r : neg_r;
              if (op_r == rau_pkg::OP_DIV && num_r == '0) begin
                st_r <= rau_pkg::ST_DIVZERO;
                state_r <= S_OUT;
              end else if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB) begin
                // gcd of dens, then aden/g and bden/g
                ga_r <= aden_r; gb_r <= den_r;
                dreq.dividend <= aden_r;
                dreq.divisor <= den_r;
                which_r <= 2'd3;
                state_r <= S_LCMW;
              end else begin
                state_r <= S_MUL1;
              end
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end
        // gcd of denominators, then q_r = bden/g, g_r = aden/g
        S_LCMW: if (drsp.done) begin
          if (which_r == 2'd3) begin
            if (drsp.rem == '0) begin
              dreq.dividend <= bden_r;
              dreq.divisor <= gb_r;
              ga_r <= gb_r;
              which_r <= 2'd2;
            end else begin
              ga_r <= gb_r; gb_r <= drsp.rem;
              dreq.dividend <= gb_r;
              dreq.divisor <= drsp.rem;
            end
          end else if (which_r == 2'd2) begin
            q_r <= drsp.quot;
            dreq.dividend <= aden_r;
            dreq.divisor <= ga_r;
            which_r <= 2'd1;
          end else begin
            g_r <= drsp.quot;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          ma_r <= prod;
          if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) num_r <= prod;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV) begin
            den_r <= prod;
            neg_r <= aneg_r ^ bneg_r;
            which_r <= 2'd2;
            state_r <= S_RED;
          end else begin
            mb_r <= prod;
            state_r <= S_MUL3;
          end
        end
        // common denominator aden * (bden/g)
        S_MUL3: begin
          den_r <= prod;
          state_r <= S_COMB;
        end
        S_COMB: begin
          if (aneg_r == bneg_r) begin
            num_r <= sum[W-1:0]; neg_r <= aneg_r;
          end else if (ma_r >= mb_r) begin
            num_r <= ma_r - mb_r; neg_r <= aneg_r;
          end else begin
            num_r <= mb_r - ma_r; neg_r <= bneg_r;
          end
          which_r <= 2'd2;
          state_r <= S_RED;
        end
        S_FIN: begin
          if (num_r > (neg_r ? half : half - 1'b1) || den_r > half - 1'b1)
            st_r <= rau_pkg::ST_OVERFLOW;
          else begin
            on_r <= neg_r ? (~num_r[rau_pkg::DW-1:0] + 1'b1) : num_r[rau_pkg::DW-1:0];
            od_r <= den_r[rau_pkg::DW-2:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done    = (state_r == S_OUT);
  assign res_st  = st_r;
  assign res_num = (st_r == rau_pkg::ST_OK) ? on_r : '0;
  assign res_den = (st_r == rau_pkg::ST_OK) ? od_r : (rau_pkg::DW-1)'(1);

endmodule

### verif/rau_checker.sv
// ---------------------------------------------------------------------------
// rau_checker: result predictor and comparator for the rational unit
// Watches both stream channels, computes the reduced fraction and status
// for every accepted item and compares each result item field by field.
// ---------------------------------------------------------------------------
module rau_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [71:0]  out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]      num;
    logic [30:0]      den;
    rau_pkg::status_t st;
  } fraction_res_t;

  fraction_res_t expected_q[$];

  // sign/magnitude fraction, magnitudes up to 64 bits
  typedef struct {
    bit          neg;
    bit [63:0]   num;
    bit [63:0]   den;
  } sfrac_t;

  function automatic bit [63:0] euclid_gcd(bit [63:0] a, bit [63:0] b);
    bit [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return (a == 0) ? 64'd1 : a;
  endfunction

  // true when a*b does not fit 64 bits
  function automatic bit prod_too_big(bit [63:0] a, bit [63:0] b, output bit [63:0] p);
    bit [127:0] w;
    w = a * b;
    p = w[63:0];
    return w[127:64] != 0;
  endfunction

  function automatic sfrac_t simplify(bit neg, bit [63:0] num, bit [63:0] den);
    sfrac_t f;
    bit [63:0] g;
    if (num == 0) begin
      den = 1;
      neg = 0;
    end
    g = euclid_gcd(num, den);
    f.neg = neg;
    f.num = num / g;
    f.den = den / g;
    return f;
  endfunction

  function automatic bit [63:0] magnitude(logic [31:0] v);
    return v[31] ? {32'd0, -v} : {32'd0, v};
  endfunction

  function automatic fraction_res_t compute_fraction(logic [135:0] d);
    fraction_res_t r;
    rau_pkg::op_t op;
    logic [31:0] ln, ld, rn, rd;
    sfrac_t a, b, q;
    bit [63:0] g, num, den, ma, mb, lim;
    bit neg, sb, ovf;
    op = rau_pkg::op_t'(d[1:0]);
    ln = d[33:2]; ld = d[65:34]; rn = d[97:66]; rd = d[129:98];
    r.num = 0;
    r.den = 1;
    if (ld == 0 || rd == 0) begin
      r.st = rau_pkg::ST_INVALID;
      return r;
    end
    a = simplify(ln[31] != ld[31], magnitude(ln), magnitude(ld));
    b = simplify(rn[31] != rd[31], magnitude(rn), magnitude(rd));
    ovf = 0;
    if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
      g = euclid_gcd(a.den, b.den);
      sb = (op == rau_pkg::OP_SUB) ? !b.neg : b.neg;
      ovf = prod_too_big(a.den / g, b.den, den) | prod_too_big(a.num, b.den / g, ma)
          | prod_too_big(b.num, a.den / g, mb);
      if (a.neg == sb) begin
        num = ma + mb;
        if (num < ma) ovf = 1;
        neg = a.neg;
      end else if (ma >= mb) begin
        num = ma - mb;
        neg = a.neg;
      end else begin
        num = mb - ma;
        neg = sb;
      end
    end else if (op == rau_pkg::OP_MUL) begin
      ovf = prod_too_big(a.num, b.num, num) | prod_too_big(a.den, b.den, den);
      neg = a.neg != b.neg;
    end else begin
      if (b.num == 0) begin
        r.st = rau_pkg::ST_DIVZERO;
        return r;
      end
      ovf = prod_too_big(a.num, b.den, num) | prod_too_big(a.den, b.num, den);
      neg = a.neg != b.neg;
    end
    if (ovf) begin
      r.st = rau_pkg::ST_OVERFLOW;
      return r;
    end
    q = simplify(neg, num, den);
    lim = q.neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (q.num > lim || q.den > 64'h7fff_ffff) begin
      r.st = rau_pkg::ST_OVERFLOW;
      return r;
    end
    r.num = q.neg ? -q.num[31:0] : q.num[31:0];
    r.den = q.den[30:0];
    r.st  = rau_pkg::ST_OK;
    return r;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    fraction_res_t got, exp_r;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(compute_fraction(in_tdata));
      if (out_tvalid && out_tready) begin
        got.num = out_tdata[31:0];
        got.den = out_tdata[62:32];
        got.st  = rau_pkg::status_t'(out_tdata[64:63]);
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.num != exp_r.num || got.den != exp_r.den || got.st != exp_r.st) begin
            $display("%0t: mismatch expected num %0d den %0d st %s, got num %0d den %0d st %s",
                     $time, $signed(exp_r.num), exp_r.den, exp_r.st.name(),
                     $signed(got.num), got.den, got.st.name());
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

### verif/tb_rational_arith_unit_core.sv
// ---------------------------------------------------------------------------
// tb_rational_arith_unit_core: testbench for the rational arithmetic unit
// Drives directed corner items and random fractions with random idling on
// both sides; the checker predicts and compares every result item.
// ---------------------------------------------------------------------------
module tb_rational_arith_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 730;
  localparam longint CYCLE_LIMIT = 50_000_000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;
  int           fail_count;
  int           pending;
  bit           no_idle = 0;
  longint       cycles = 0;

  always #5 clk = ~clk;

  rational_arith_unit_core i_dut (.*);

  rau_checker i_checker (.*);

  // receiver stalls at random, about 21 percent of the time, never while no_idle is set
  always @(negedge clk)
    out_tready <= no_idle || ($urandom_range(99) >= 21);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rational_arith_unit_core failed");
      $finish;
    end
  end

  // send one item, holding it until accepted; valid stays up until the
  // next item or an idle cycle replaces it
  task automatic send_item(rau_pkg::op_t op, logic [31:0] ln, logic [31:0] ld,
                           logic [31:0] rn, logic [31:0] rd);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {6'd0, rd, rn, ld, ln, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // random value biased toward small magnitudes and corners
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3, 4:    return $urandom;
      5:       return $urandom_range(65535) - 32768;
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  logic [31:0] corners[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                              32'h0, 32'h1, 32'h0001_0000};

  initial begin
    rau_pkg::op_t op;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: every operation, zero denominators, zero numerators, extremes
    for (int i = 0; i < 4; i++) begin
      op = rau_pkg::op_t'(i);
      send_item(op, 1, 2, 1, 3);
      send_item(op, 5, 0, 1, 3);
      send_item(op, 0, -7, 3, 9);
      send_item(op, 32'h8000_0000, -1, 32'h8000_0000, 32'h7fff_ffff);
    end
    send_item(rau_pkg::OP_DIV, 3, 4, 0, 5);
    send_item(rau_pkg::OP_DIV, 3, 4, 1, 0);
    send_item(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    send_item(rau_pkg::OP_SUB, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000, 32'h7fff_fffd);
    send_item(rau_pkg::OP_ADD, 6, -4, -9, 6);
    in_tvalid <= 0;
    // sender holds off until all results are back
    while (pending != 0) @(negedge clk);
    // random part: corner values first, then mixed values; no idling for items 100 to 199
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 100 && n < 200);
      op = rau_pkg::op_t'($urandom_range(3));
      if (n < 60)
        send_item(op, corners[$urandom_range(5)], corners[$urandom_range(5)],
                  corners[$urandom_range(5)], corners[$urandom_range(5)]);
      else
        send_item(op, pick_value(), ($urandom_range(30) == 0) ? 32'd0 : pick_value(),
                  pick_value(), ($urandom_range(30) == 0) ? 32'd0 : pick_value());
    end
    in_tvalid <= 0;
    no_idle = 0;
    while (pending != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    if (fail_count == 0)
      $display("tb_rational_arith_unit_core passed");
    else
      $display("tb_rational_arith_unit_core failed");
    $finish;
  end

endmodule
